// ===== rtl/periodic_timer_slot_table_core_macros.svh =====
// Assertion helpers used by the checker file.
// Each helper samples on clk and is disabled while rst_n is low.
`ifndef PERIODIC_TIMER_SLOT_TABLE_CORE_MACROS_SVH
`define PERIODIC_TIMER_SLOT_TABLE_CORE_MACROS_SVH

// Same-cycle implication.
`define PTST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot table check failed");

// Delayed implication: the consequent is checked later than the antecedent.
`define PTST_ASSERT_DLY2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("slot table latency check failed");

`endif

// ===== rtl/ptst_pkg.sv =====
package ptst_pkg;

  localparam int SLOTS       = 4;
  localparam int COUNT_BITS  = 16;
  localparam int PERIOD_BITS = 16;
  localparam int SLOT_IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_BITS    = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
  localparam int MASK_BITS   = 4;
  localparam int SLOT_BITS   = 2;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_START  = 2'd1;
  localparam cmd_t CMD_CANCEL = 2'd2;

  typedef struct packed {
    cmd_t                   cmd;
    logic [PERIOD_BITS-1:0] period;
    logic [1:0]             slot_index;
  } in_item_t;

  typedef struct packed {
    logic [MASK_BITS-1:0] fired_mask;
    logic [SLOT_BITS-1:0] slot;
    logic                 full_res;
  } out_item_t;

  // Registered command handed to the slot table.
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } stage_t;

endpackage

// ===== rtl/ptst_cmd_reg.sv =====
module ptst_cmd_reg
  import ptst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  output stage_t   stage
);

  logic     vld_r;
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

// ===== rtl/ptst_slot_table.sv =====
module ptst_slot_table
  import ptst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stage_t    stage,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [SLOTS-1:0]       active_r;
  logic [SLOTS-1:0]       active_nxt;
  logic [COUNT_BITS-1:0]  count_r     [SLOTS];
  logic [COUNT_BITS-1:0]  count_nxt   [SLOTS];
  logic [PERIOD_BITS-1:0] period_r    [SLOTS];
  logic [PERIOD_BITS-1:0] period_nxt  [SLOTS];
  logic [SLOTS-1:0]       fired;
  logic [SLOT_IW-1:0]     claim;
  logic                   found;
  logic                   full;
  out_item_t              res;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // Lowest free slot
  always_comb begin
    found = 1'b0;
    claim = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!found && !active_r[s]) begin
        found = 1'b1;
        claim = SLOT_IW'(s);
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    period_nxt = period_r;
    fired      = '0;
    full       = 1'b0;
    if (stage.vld) begin
      unique case (stage.item.cmd)
        CMD_TICK: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (active_r[s]) begin
              if (CMP_BITS'(count_r[s]) >= CMP_BITS'(period_r[s])) begin
                count_nxt[s] = '0;
                fired[s]     = 1'b1;
              end else begin
                count_nxt[s] = count_r[s] + COUNT_BITS'(1);
              end
            end
          end
        end
        CMD_START: begin
          if (found) begin
            active_nxt[claim] = 1'b1;
            period_nxt[claim] = stage.item.period;
            count_nxt[claim]  = '0;
          end else begin
            full = 1'b1;
          end
        end
        CMD_CANCEL: begin
          // indexes beyond the table match no slot
          for (int s = 0; s < SLOTS; s++) begin
            if (32'(s) == 32'(stage.item.slot_index)) begin
              active_nxt[s] = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res = '0;
    for (int b = 0; b < MASK_BITS; b++) begin
      if (b < SLOTS) begin
        res.fired_mask[b] = fired[b];
      end
    end
    if (stage.item.cmd == CMD_START && found) begin
      res.slot = SLOT_BITS'(claim);
    end
    res.full_res = full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      count_r     <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      out_valid_r <= stage.vld;
    end
  end

  always_ff @(posedge clk) begin
    period_r   <= period_nxt;
    out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/periodic_timer_slot_table_core.sv =====
// Periodic timer slot table.
// Input: raise start with in_item (cmd, period, slot_index); the command is
// taken on that clock edge. busy stays low, so a command may be issued in
// every cycle.
//   tick   - advance every active slot, report the slots that wrap.
//   start  - claim the lowest free slot with the given period, or report full.
//   cancel - free the slot named by slot_index.
// Output: each command yields one result on out_item, shown for exactly one
// cycle with out_valid high, after the command register and the result
// register. The receiver cannot hold results off; results leave in command
// order. Throughput is one command per cycle: the command register feeds
// one pass of compare and increment per slot in parallel, straight into the
// result register.
// Reset (rst_n low, synchronous) frees all slots, clears all counts and
// drops any command in flight.
module periodic_timer_slot_table_core
  import ptst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic   accept;
  stage_t stage;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ptst_cmd_reg u_cmd_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .stage   (stage)
  );

  ptst_slot_table u_slot_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/ptst_checker.sv =====
`include "periodic_timer_slot_table_core_macros.svh"

module ptst_checker
  import ptst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  logic is_start_cmd;
  logic is_tick_cmd;
  logic res_clear;
  logic fired_any;

  assign is_start_cmd = (in_item.cmd == CMD_START);
  assign is_tick_cmd  = (in_item.cmd == CMD_TICK);
  assign res_clear    = (out_item.slot == '0) && (out_item.fired_mask == '0);
  assign fired_any    = |out_item.fired_mask;

  // every transfer in yields a result after the command and result registers
  `PTST_ASSERT_DLY2(a_latency, start && !busy, out_valid)

  // no result without a transfer in
  `PTST_ASSERT_NOW(a_no_spurious, out_valid, $past(start && !busy, 2))

  // full only answers a start
  `PTST_ASSERT_NOW(a_full_from_start, out_valid && out_item.full_res, $past(is_start_cmd, 2))

  // a full answer carries no slot and no fired bits
  `PTST_ASSERT_NOW(a_full_clean, out_valid && out_item.full_res, res_clear)

  // only a tick fires slots
  `PTST_ASSERT_NOW(a_fire_from_tick, out_valid && fired_any, $past(is_tick_cmd, 2))

endmodule

bind periodic_timer_slot_table_core ptst_checker u_ptst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
